// File: hw/rtl/usb_battery_charge_manager_macros.svh
// Assertion macros shared by the charge manager RTL.
`ifndef USB_BATTERY_CHARGE_MANAGER_MACROS_SVH
`define USB_BATTERY_CHARGE_MANAGER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define UBCM_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("charge manager check failed");

// Next-cycle implication, disabled while reset is high.
`define UBCM_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("charge manager check failed");

`endif

// File: hw/rtl/ubcm_pkg.sv
// Types, codes and reset constants of the USB battery charge manager.
`default_nettype none

package ubcm_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_USB   = 2'd1;
  localparam logic [1:0] CMD_LIGHT = 2'd2;

  localparam logic [1:0] MODE_IDLE      = 2'd0;
  localparam logic [1:0] MODE_DISCHARGE = 2'd1;
  localparam logic [1:0] MODE_USB       = 2'd2;

  localparam logic [1:0] TEMP_OK      = 2'd0;
  localparam logic [1:0] TEMP_HIGH    = 2'd1;
  localparam logic [1:0] TEMP_REMOVED = 2'd2;

  localparam logic [1:0] VOLT_OK   = 2'd0;
  localparam logic [1:0] VOLT_LOW  = 2'd1;
  localparam logic [1:0] VOLT_CRIT = 2'd2;

  localparam logic [1:0] CHIP_INIT     = 2'd0;
  localparam logic [1:0] CHIP_CHARGING = 2'd1;
  localparam logic [1:0] CHIP_DONE     = 2'd2;
  localparam logic [1:0] CHIP_FAULT    = 2'd3;

  localparam logic [2:0] STAT_IDLE     = 3'd0;
  localparam logic [2:0] STAT_CHARGING = 3'd1;
  localparam logic [2:0] STAT_DONE     = 3'd2;
  localparam logic [2:0] STAT_CFAULT   = 3'd3;
  localparam logic [2:0] STAT_TFAULT   = 3'd4;
  localparam logic [2:0] STAT_NOBAT    = 3'd5;
  localparam logic [2:0] STAT_CRIT     = 3'd6;

  localparam logic [1:0] REG_CHARGE_SETTLE  = 2'd0;
  localparam logic [1:0] REG_BATTERY_SETTLE = 2'd1;
  localparam logic [1:0] REG_SESSION_LIMIT  = 2'd2;

  localparam logic [15:0] CHARGE_SETTLE_RST  = 16'd500;
  localparam logic [15:0] BATTERY_SETTLE_RST = 16'd500;
  localparam logic [31:0] SESSION_LIMIT_RST  = 32'd28800000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] elapsed_ms;
    logic        usb_connected;
    logic        light_active;
    logic [1:0]  temp_code;
    logic [1:0]  volt_code;
    logic        charge_on_readback;
    logic [1:0]  chip_code;
  } item_t;

  typedef struct packed {
    logic        battery_out;
    logic        charge_on;
    logic        fast_charge;
    logic [2:0]  charge_status;
    logic        chip_valid;
    logic        chip_charging;
    logic        charge_report;
    logic [1:0]  volt_level;
    logic        volt_report;
    logic [1:0]  run_state;
    logic        path_ready;
    logic        unplug_prepare;
  } res_t;

  typedef struct packed {
    logic [15:0] charge_settle;
    logic [15:0] battery_settle;
    logic [31:0] session_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        on_usb;
    logic        light_on;
    logic        dis_en;
    logic        vpoll;
    logic [15:0] bat_left;
    logic [15:0] chg_left;
    logic [31:0] sess;
    logic        sess_to;
    logic        apply_pend;
    logic        fade_pend;
    logic        rep_valid;
    logic        rep_cv;
    logic        rep_cc;
    logic        rep_fast;
    logic [2:0]  rep_status;
    logic [1:0]  rep_level;
    logic        chg_cmd;
    logic        fast_cmd;
    logic [2:0]  cur_status;
    logic        cur_cv;
    logic        cur_cc;
    logic        cur_fast;
  } st_t;

endpackage

`default_nettype wire

// File: hw/rtl/ubcm_in_if.sv
// Input item channel of the charge manager.
`default_nettype none

interface ubcm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] elapsed_ms;
  logic        usb_connected;
  logic        light_active;
  logic [1:0]  temp_code;
  logic [1:0]  volt_code;
  logic        charge_on_readback;
  logic [1:0]  chip_code;

  modport source (
    output valid, cmd, elapsed_ms, usb_connected, light_active, temp_code, volt_code,
           charge_on_readback, chip_code,
    input  ready
  );
  modport sink (
    input  valid, cmd, elapsed_ms, usb_connected, light_active, temp_code, volt_code,
           charge_on_readback, chip_code,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/ubcm_out_if.sv
// Result item channel of the charge manager.
`default_nettype none

interface ubcm_out_if;
  logic       valid;
  logic       ready;
  logic       battery_out;
  logic       charge_on;
  logic       fast_charge;
  logic [2:0] charge_status;
  logic       chip_valid;
  logic       chip_charging;
  logic       charge_report;
  logic [1:0] volt_level;
  logic       volt_report;
  logic [1:0] run_state;
  logic       path_ready;
  logic       unplug_prepare;

  modport source (
    output valid, battery_out, charge_on, fast_charge, charge_status, chip_valid,
           chip_charging, charge_report, volt_level, volt_report, run_state,
           path_ready, unplug_prepare,
    input  ready
  );
  modport sink (
    input  valid, battery_out, charge_on, fast_charge, charge_status, chip_valid,
           chip_charging, charge_report, volt_level, volt_report, run_state,
           path_ready, unplug_prepare,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/ubcm_cfg_if.sv
// Configuration write channel of the charge manager.
`default_nettype none

interface ubcm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ubcm_cfg.sv
// Configuration registers of the charge manager.
`default_nettype none

module ubcm_cfg
  import ubcm_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  ubcm_cfg_if.sink    cfg,
  output cfg_t        regs
);

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.charge_settle  <= CHARGE_SETTLE_RST;
      regs.battery_settle <= BATTERY_SETTLE_RST;
      regs.session_limit  <= SESSION_LIMIT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CHARGE_SETTLE:  regs.charge_settle  <= cfg.data[15:0];
        REG_BATTERY_SETTLE: regs.battery_settle <= cfg.data[15:0];
        REG_SESSION_LIMIT:  regs.session_limit  <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ubcm_step.sv
// Next-state and result logic for one item of the charge manager.
`default_nettype none

module ubcm_step
  import ubcm_pkg::*;
(
  input  st_t   cur,
  input  item_t item,
  input  cfg_t  regs,
  output st_t   nxt,
  output res_t  res
);

  typedef struct packed {
    logic [1:0] temp;
    logic [1:0] volt;
    logic [1:0] chip;
    logic       en;
  } smp_t;

  st_t         s;
  smp_t        m;
  logic        p_report;
  logic        p_volt;
  logic        p_ready;
  logic        p_prep;
  logic        restore;
  logic        chip_ok;
  logic [1:0]  lvl;
  logic [32:0] sum;

  function automatic smp_t fetch(item_t it, logic vpoll, logic [15:0] bat_left);
    smp_t f;
    f = '0;
    if (it.usb_connected) begin
      f.temp = it.temp_code;
      f.volt = it.volt_code;
      f.en   = it.charge_on_readback;
      f.chip = it.charge_on_readback ? it.chip_code : CHIP_INIT;
    end else if (vpoll && (bat_left == '0)) begin
      f.volt = it.volt_code;
    end
    return f;
  endfunction

  function automatic st_t charge_control(st_t s0, smp_t f, logic [15:0] cset);
    st_t        r;
    logic       cv;
    logic [2:0] st;
    logic       allow;
    r  = s0;
    cv = f.en && (s0.chg_left == '0);
    if (f.temp == TEMP_REMOVED) st = STAT_NOBAT;
    else if (f.temp == TEMP_HIGH) st = STAT_TFAULT;
    else if (cv && f.chip == CHIP_FAULT) st = STAT_CFAULT;
    else if (cv && f.volt == VOLT_CRIT) st = STAT_CRIT;
    else if (cv && f.chip == CHIP_CHARGING) st = STAT_CHARGING;
    else if (cv && f.chip == CHIP_DONE) st = STAT_DONE;
    else if (s0.sess_to) st = STAT_DONE;
    else if (f.en) st = STAT_CHARGING;
    else st = STAT_IDLE;
    allow = (st == STAT_CHARGING) || (st == STAT_IDLE);
    r.chg_cmd  = allow;
    r.fast_cmd = !s0.light_on;
    if (allow && !f.en) r.chg_left = cset;
    else if (!allow) r.chg_left = '0;
    r.cur_status = st;
    r.cur_fast   = !s0.light_on;
    r.cur_cv     = cv;
    r.cur_cc     = cv && (f.chip == CHIP_CHARGING);
    return r;
  endfunction

  function automatic logic report_ind(st_t s0);
    return s0.on_usb && (!s0.rep_valid || (s0.cur_status != s0.rep_status) ||
                         (s0.cur_cv != s0.rep_cv) || (s0.cur_cc != s0.rep_cc));
  endfunction

  function automatic st_t report_upd(st_t s0);
    st_t r;
    r = s0;
    if (report_ind(s0) || (s0.on_usb && (s0.cur_fast != s0.rep_fast))) begin
      r.rep_status = s0.cur_status;
      r.rep_cv     = s0.cur_cv;
      r.rep_cc     = s0.cur_cc;
      r.rep_fast   = s0.cur_fast;
      r.rep_valid  = 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    s        = cur;
    m        = '0;
    p_report = 1'b0;
    p_volt   = 1'b0;
    p_ready  = 1'b0;
    p_prep   = 1'b0;
    restore  = 1'b0;
    chip_ok  = 1'b0;
    lvl      = VOLT_OK;
    sum      = '0;
    case (item.cmd)
      CMD_TICK: begin
        if (s.mode == MODE_DISCHARGE) begin
          if (s.bat_left != '0) begin
            s.bat_left = (item.elapsed_ms >= s.bat_left) ? '0 : s.bat_left - item.elapsed_ms;
          end
        end else if (s.mode == MODE_USB) begin
          if (s.chg_left != '0) begin
            s.chg_left = (item.elapsed_ms >= s.chg_left) ? '0 : s.chg_left - item.elapsed_ms;
          end
        end
        m        = fetch(item, s.vpoll, s.bat_left);
        s.on_usb = item.usb_connected;
        if (s.apply_pend) begin
          s.apply_pend = 1'b0;
          if (s.on_usb) begin
            s.bat_left = '0;
            s.dis_en   = 1'b0;
            s.vpoll    = 1'b0;
            s          = charge_control(s, m, regs.charge_settle);
            p_report   = report_ind(s);
            s          = report_upd(s);
            p_prep     = s.fade_pend;
            s.fade_pend = 1'b0;
            p_ready    = 1'b1;
          end else begin
            restore = s.fade_pend;
            p_prep  = restore;
            if (restore || s.light_on) begin
              if (!s.dis_en) begin
                s.dis_en   = 1'b1;
                s.bat_left = regs.battery_settle;
              end
              s.vpoll     = 1'b1;
              s.fade_pend = 1'b0;
              p_ready     = 1'b1;
            end else begin
              s.bat_left = '0;
              s.dis_en   = 1'b0;
              s.vpoll    = 1'b0;
            end
          end
        end
        if (s.mode == MODE_DISCHARGE) begin
          if (s.vpoll && (s.bat_left == '0) && !s.on_usb) begin
            lvl = (m.volt == VOLT_CRIT) ? VOLT_CRIT :
                  ((m.volt == VOLT_LOW) ? VOLT_LOW : VOLT_OK);
            if (lvl != s.rep_level) begin
              s.rep_level = lvl;
              p_volt      = 1'b1;
              if (lvl == VOLT_CRIT) begin
                s.bat_left = '0;
                s.dis_en   = 1'b0;
                s.vpoll    = 1'b0;
                s.mode     = MODE_IDLE;
              end
            end
          end
        end else if (s.mode == MODE_USB) begin
          chip_ok = m.en && (s.chg_left == '0);
          if (!s.on_usb) begin
            s.sess    = '0;
            s.sess_to = 1'b0;
          end else if (!s.sess_to) begin
            if (!chip_ok) begin
              s.sess = '0;
            end else if (m.chip == CHIP_DONE) begin
              s.sess    = '0;
              s.sess_to = 1'b0;
            end else if (m.chip != CHIP_FAULT) begin
              sum    = {1'b0, s.sess} + {17'd0, item.elapsed_ms};
              s.sess = sum[32] ? '1 : sum[31:0];
              if (s.sess >= regs.session_limit) s.sess_to = 1'b1;
            end
          end
          s        = charge_control(s, m, regs.charge_settle);
          p_report = p_report | report_ind(s);
          s        = report_upd(s);
        end
      end
      CMD_USB: begin
        if (item.usb_connected) begin
          s.on_usb   = 1'b1;
          s.chg_left = regs.charge_settle;
          s.bat_left = '0;
          s.dis_en   = 1'b0;
        end else begin
          s.on_usb     = 1'b0;
          s.chg_cmd    = 1'b0;
          s.fast_cmd   = 1'b0;
          p_report     = s.rep_valid;
          s.rep_valid  = 1'b0;
          s.rep_status = STAT_IDLE;
          s.rep_cv     = 1'b0;
          s.rep_cc     = 1'b0;
          s.rep_fast   = 1'b0;
          s.cur_status = STAT_IDLE;
          s.cur_cv     = 1'b0;
          s.cur_cc     = 1'b0;
          s.cur_fast   = 1'b0;
          s.chg_left   = '0;
          s.sess       = '0;
          s.sess_to    = 1'b0;
          s.fade_pend  = s.light_on;
        end
        s.mode       = s.on_usb ? MODE_USB : (s.light_on ? MODE_DISCHARGE : MODE_IDLE);
        s.apply_pend = 1'b1;
      end
      CMD_LIGHT: begin
        if (s.light_on != item.light_active) begin
          s.light_on = item.light_active;
          m          = fetch(item, s.vpoll, s.bat_left);
          s.on_usb   = item.usb_connected;
          s.mode     = s.on_usb ? MODE_USB : (s.light_on ? MODE_DISCHARGE : MODE_IDLE);
          if (!s.on_usb) begin
            s.vpoll = s.light_on;
            if (s.light_on) begin
              if (!s.dis_en) begin
                s.dis_en   = 1'b1;
                s.bat_left = regs.battery_settle;
              end
              p_prep      = s.fade_pend;
              s.fade_pend = 1'b0;
              p_ready     = 1'b1;
            end else begin
              s.bat_left = '0;
              s.dis_en   = 1'b0;
            end
          end else begin
            s        = charge_control(s, m, regs.charge_settle);
            p_report = report_ind(s);
            s        = report_upd(s);
          end
        end
      end
      default: ;
    endcase
  end

  assign nxt = s;

  always_comb begin
    res.battery_out    = s.dis_en;
    res.charge_on      = s.chg_cmd;
    res.fast_charge    = s.fast_cmd;
    res.charge_status  = s.cur_status;
    res.chip_valid     = s.cur_cv;
    res.chip_charging  = s.cur_cc;
    res.charge_report  = p_report;
    res.volt_level     = s.rep_level;
    res.volt_report    = p_volt;
    res.run_state      = s.mode;
    res.path_ready     = p_ready;
    res.unplug_prepare = p_prep;
  end

endmodule

`default_nettype wire

// File: hw/rtl/usb_battery_charge_manager.sv
// USB battery charge manager top level.
// One item (poll tick, USB plug event or main-light event) is taken per clock cycle while
// the result side keeps taking items. An accepted item is held in an input register, its
// whole state update and result are computed combinationally by next-state logic, and
// the result lands in an output register as the item leaves the input register. The
// sustained rate is one item per cycle while the result side keeps taking items. A
// waiting result holds the input register, so at most two items are inside the block.
// The tick path, with its settle countdown, 32-bit session add and limit compare and the
// status resolution, is the longest. Configuration writes are taken at any time outside
// reset and must only be made while no item is in flight.
`default_nettype none

module usb_battery_charge_manager
  import ubcm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  ubcm_in_if.sink    item_in,
  ubcm_out_if.source result_out,
  ubcm_cfg_if.sink   cfg
);

  `include "usb_battery_charge_manager_macros.svh"

  cfg_t  regs;
  item_t item_q;
  logic  in_valid;
  st_t   state;
  st_t   state_next;
  res_t  res_next;
  res_t  res_q;
  logic  out_valid;
  logic  advance;

  ubcm_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ubcm_step u_step (
    .cur  (state),
    .item (item_q),
    .regs (regs),
    .nxt  (state_next),
    .res  (res_next)
  );

  assign advance       = in_valid && (!out_valid || result_out.ready);
  assign item_in.ready = !rst && (!in_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_in.ready) begin
      in_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      item_q.cmd                <= item_in.cmd;
      item_q.elapsed_ms         <= item_in.elapsed_ms;
      item_q.usb_connected      <= item_in.usb_connected;
      item_q.light_active       <= item_in.light_active;
      item_q.temp_code          <= item_in.temp_code;
      item_q.volt_code          <= item_in.volt_code;
      item_q.charge_on_readback <= item_in.charge_on_readback;
      item_q.chip_code          <= item_in.chip_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      state     <= state_next;
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.battery_out    = res_q.battery_out;
  assign result_out.charge_on      = res_q.charge_on;
  assign result_out.fast_charge    = res_q.fast_charge;
  assign result_out.charge_status  = res_q.charge_status;
  assign result_out.chip_valid     = res_q.chip_valid;
  assign result_out.chip_charging  = res_q.chip_charging;
  assign result_out.charge_report  = res_q.charge_report;
  assign result_out.volt_level     = res_q.volt_level;
  assign result_out.volt_report    = res_q.volt_report;
  assign result_out.run_state      = res_q.run_state;
  assign result_out.path_ready     = res_q.path_ready;
  assign result_out.unplug_prepare = res_q.unplug_prepare;

  `UBCM_ASSERT_NOW(a_settle_needs_discharge, clk, rst, state.bat_left != '0, state.dis_en)
  `UBCM_ASSERT_NOW(a_prepare_with_ready, clk, rst, out_valid && res_q.unplug_prepare, res_q.path_ready)
  `UBCM_ASSERT_NEXT(a_stall_holds_state, clk, rst, out_valid && !result_out.ready, $stable(state))
  `UBCM_ASSERT_NEXT(a_advance_gives_result, clk, rst, advance, out_valid)

endmodule

`default_nettype wire
